[src/isort_pkg.sv]
// ----------------------------------------------------------------------------
// isort_pkg
// shared constants, types and the compare rule of the insertion sorter
// ----------------------------------------------------------------------------
package isort_pkg;

    localparam int CAPACITY = 8;
    localparam int VALUE_W  = 32;

    typedef logic signed [VALUE_W-1:0] value_t;

    // what one cell shows its neighbours
    typedef struct packed {
        logic   valid;
        logic   moves;
        value_t data;
    } cell_link_t;

    // common strobes from the sequencer to every cell
    typedef struct packed {
        logic   insert;
        logic   shift;
        logic   descending;
        value_t key;
    } cell_ctrl_t;

    // true if a stored entry must sit behind the new key
    function automatic logic moves_past(input value_t stored, input value_t key,
                                        input logic descending);
        logic res;
        if (descending)
        begin
            res = key > stored;
        end
        else
        begin
            res = stored > key;
        end
        return res;
    endfunction

endpackage

[src/isort_if.sv]
// ----------------------------------------------------------------------------
// isort_if
// valid/ready channels of the insertion sorter
// ----------------------------------------------------------------------------
interface isort_in_if;
    logic                  valid;
    logic                  ready;
    isort_pkg::value_t     value;
    logic                  last_in;

    modport source (output valid, output value, output last_in, input ready);
    modport sink   (input valid, input value, input last_in, output ready);
endinterface

interface isort_out_if;
    logic                  valid;
    logic                  ready;
    isort_pkg::value_t     sorted_value;
    logic                  last_out;
    logic                  dropped;

    modport source (output valid, output sorted_value, output last_out,
                    output dropped, input ready);
    modport sink   (input valid, input sorted_value, input last_out,
                    input dropped, output ready);
endinterface

interface isort_cfg_if;
    logic valid;
    logic ready;
    logic descending;

    modport source (output valid, output descending, input ready);
    modport sink   (input valid, input descending, output ready);
endinterface

[src/insertion_sorter.sv]
// ----------------------------------------------------------------------------
// insertion_sorter
// stable insertion sort of signed 32-bit values in a chain of cells
// ----------------------------------------------------------------------------
// usage
//   feed   : value beats with last_in; one beat per cycle while ready is high
//   result : sorted_value beats, last_out on the final one, dropped when the
//            set overflowed the CAPACITY cells
//   cfg    : one-bit descending register, always ready, write only when idle
// throughput
//   one value per cycle while filling: every cell compares against the key
//   and shifts in the same cycle
//   after the last_in beat the chain drains one cell per cycle through the
//   output register while the result is taken; feed.ready is low for the drain
// first result
//   last_in sets draining_reg, then the head cell loads the output register
// reset
//   cells empty, overflow flag clear, ascending order
// stall
//   a stalled result holds; the chain waits until the register frees up
// ----------------------------------------------------------------------------
module insertion_sorter (
    input  logic        clk,
    input  logic        rst_n,
    isort_in_if.sink    feed,
    isort_out_if.source result,
    isort_cfg_if.sink   cfg
);

    localparam int N = isort_pkg::CAPACITY;

    // configuration
    logic descending_reg;

    // sequencer state
    logic draining_reg;
    logic draining_next;
    logic overflow_reg;
    logic overflow_next;

    // output register
    logic              out_valid_reg;
    isort_pkg::value_t out_value_reg;
    logic              out_last_reg;
    logic              out_dropped_reg;

    isort_pkg::cell_ctrl_t ctrl;
    isort_pkg::cell_link_t links [N];
    logic [N-1:0]          valid_vec;

    logic feed_beat;
    logic full;
    logic load_out;
    logic drain_end;

    assign cfg.ready  = 1'b1;
    assign feed.ready = !draining_reg;
    assign feed_beat  = feed.valid && feed.ready;
    assign full       = valid_vec[N-1];

    // while draining, move the head cell into the output register when it is free
    assign load_out  = draining_reg && (!out_valid_reg || result.ready);
    assign drain_end = load_out && !valid_vec[1];

    assign ctrl.insert     = feed_beat && !full;
    assign ctrl.shift      = load_out;
    assign ctrl.descending = descending_reg;
    assign ctrl.key        = feed.value;

    // chain of cells; the head sees an always-valid, non-moving left side
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        isort_pkg::cell_link_t left_link;
        isort_pkg::cell_link_t right_link;

        if (i == 0)
        begin : g_head
            assign left_link = '{valid: 1'b1, moves: 1'b0, data: '0};
        end
        else
        begin : g_body
            assign left_link = links[i-1];
        end

        if (i == N - 1)
        begin : g_tail
            assign right_link = '{valid: 1'b0, moves: 1'b0, data: '0};
        end
        else
        begin : g_mid
            assign right_link = links[i+1];
        end

        isort_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .left  (left_link),
            .right (right_link),
            .self  (links[i])
        );

        assign valid_vec[i] = links[i].valid;
    end

    always_comb
    begin
        draining_next = draining_reg;
        overflow_next = overflow_reg;
        priority if (drain_end)
        begin
            draining_next = 1'b0;
            overflow_next = 1'b0;
        end
        else if (feed_beat)
        begin
            overflow_next = overflow_reg || full;
            draining_next = feed.last_in;
        end
        else
        begin
            draining_next = draining_reg;
            overflow_next = overflow_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            descending_reg <= 1'b0;
            draining_reg   <= 1'b0;
            overflow_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                descending_reg <= cfg.descending;
            end
            draining_reg <= draining_next;
            overflow_reg <= overflow_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload of the output register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_value_reg   <= links[0].data;
            out_last_reg    <= !valid_vec[1];
            out_dropped_reg <= overflow_reg;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.sorted_value = out_value_reg;
    assign result.last_out     = out_last_reg;
    assign result.dropped      = out_dropped_reg;

    // occupied cells always form an unbroken run from the head
    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + N'(1))) == '0)
        else $error("gap in occupied cells");

    // while draining the head cell has a value to hand out
    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        draining_reg |-> valid_vec[0])
        else $error("drain with empty head cell");

    // the beat flagged last ends the drain and leaves the chain empty
    a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
        drain_end |=> (!draining_reg && valid_vec == '0 && out_last_reg))
        else $error("drain did not end cleanly");

endmodule

[src/isort_cell.sv]
// ----------------------------------------------------------------------------
// isort_cell
// one slot of the sorted chain: compare, take from left, key, or right
// ----------------------------------------------------------------------------
module isort_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  isort_pkg::cell_ctrl_t   ctrl,
    input  isort_pkg::cell_link_t   left,
    input  isort_pkg::cell_link_t   right,
    output isort_pkg::cell_link_t   self
);

    logic              valid_reg;
    logic              valid_next;
    isort_pkg::value_t data_reg;
    isort_pkg::value_t data_next;
    logic              moves;

    assign moves = valid_reg && isort_pkg::moves_past(data_reg, ctrl.key, ctrl.descending);

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        priority if (ctrl.shift)
        begin
            valid_next = right.valid;
            data_next  = right.data;
        end
        else if (ctrl.insert && left.moves)
        begin
            valid_next = 1'b1;
            data_next  = left.data;
        end
        else if (ctrl.insert && left.valid && (!valid_reg || moves))
        begin
            valid_next = 1'b1;
            data_next  = ctrl.key;
        end
        else
        begin
            valid_next = valid_reg;
            data_next  = data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign self.valid = valid_reg;
    assign self.moves = moves;
    assign self.data  = data_reg;

endmodule
